@@ hdl/mi3_pkg.sv @@
// package for the 3x3 fixed-point matrix inverse
// word types, element and intermediate widths, remainder width helper
// no dependencies
`default_nettype none
package mi3_pkg;

  localparam int ELEM_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_ENT       = 9;
  localparam int PROD_W        = 2 * ELEM_WIDTH;
  localparam int ADJ_W         = 2 * ELEM_WIDTH + 1;
  localparam int DET_W         = 3 * ELEM_WIDTH + 2;
  localparam int QUO_W         = ELEM_WIDTH + 1;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [ADJ_W-1:0]      adj_t;
  typedef logic signed [DET_W-1:0]      det_t;

  typedef struct packed {
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } in_word_t;

  typedef struct packed {
    elem_t out_r0c0;
    elem_t out_r0c1;
    elem_t out_r0c2;
    elem_t out_r1c0;
    elem_t out_r1c1;
    elem_t out_r1c2;
    elem_t out_r2c0;
    elem_t out_r2c1;
    elem_t out_r2c2;
    logic  singular;
    logic  saturated;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic [NUM_ENT-1:0] neg;
  } div_side_t;

  function automatic int rem_width(int frac);
    int nw;
    nw = ADJ_W + 2 * frac + 1;
    if (nw < DET_W) nw = DET_W;
    nw = nw + 1;
    if (nw < DET_W + 1 + ELEM_WIDTH) nw = DET_W + 1 + ELEM_WIDTH;
    return nw + 1;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mi3_front.sv @@
// cofactor and determinant pipeline, five register stages
// depends on mi3_pkg
`default_nettype none
module mi3_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire mi3_pkg::in_word_t word_i,
  output logic                   valid_o,
  output mi3_pkg::adj_t          adj_o [mi3_pkg::NUM_ENT],
  output mi3_pkg::det_t          det_o
);
  import mi3_pkg::*;

  localparam int HPW = 2 * ELEM_WIDTH + 1;
  localparam int OP_P [NUM_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int OP_Q [NUM_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int OP_R [NUM_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int OP_S [NUM_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};

  elem_t m [NUM_ENT];

  logic [4:0] v_q;
  logic signed [PROD_W-1:0] pa_q [NUM_ENT];
  logic signed [PROD_W-1:0] pb_q [NUM_ENT];
  elem_t r1_q [3];
  elem_t r2_q [3];
  adj_t  adj2_q [NUM_ENT];
  adj_t  adj3_q [NUM_ENT];
  adj_t  adj4_q [NUM_ENT];
  adj_t  adj5_q [NUM_ENT];
  logic signed [HPW-1:0] hp_q [3];
  logic signed [HPW-1:0] lp_q [3];
  det_t  t_q [3];
  det_t  det_q;

  logic signed [ELEM_WIDTH:0] hi_w [3];
  logic signed [ELEM_WIDTH:0] lo_w [3];

  always_comb begin
    m[0] = word_i.in_r0c0;
    m[1] = word_i.in_r0c1;
    m[2] = word_i.in_r0c2;
    m[3] = word_i.in_r1c0;
    m[4] = word_i.in_r1c1;
    m[5] = word_i.in_r1c2;
    m[6] = word_i.in_r2c0;
    m[7] = word_i.in_r2c1;
    m[8] = word_i.in_r2c2;
  end

  // det uses adjugate entries 00, 10, 20
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hi_w[j] = $signed(adj2_q[3*j][ADJ_W-1:ELEM_WIDTH]);
      lo_w[j] = $signed({1'b0, adj2_q[3*j][ELEM_WIDTH-1:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        pa_q[k]   <= PROD_W'(m[OP_P[k]]) * PROD_W'(m[OP_S[k]]);
        pb_q[k]   <= PROD_W'(m[OP_Q[k]]) * PROD_W'(m[OP_R[k]]);
        adj2_q[k] <= ADJ_W'(pa_q[k]) - ADJ_W'(pb_q[k]);
        adj3_q[k] <= adj2_q[k];
        adj4_q[k] <= adj3_q[k];
        adj5_q[k] <= adj4_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        r1_q[j] <= m[j];
        r2_q[j] <= r1_q[j];
        hp_q[j] <= HPW'(r2_q[j]) * HPW'(hi_w[j]);
        lp_q[j] <= HPW'(r2_q[j]) * HPW'(lo_w[j]);
        t_q[j]  <= (DET_W'(hp_q[j]) <<< ELEM_WIDTH) + DET_W'(lp_q[j]);
      end
      det_q <= t_q[0] + t_q[1] + t_q[2];
    end
  end

  assign valid_o = v_q[4];
  assign adj_o   = adj5_q;
  assign det_o   = det_q;

endmodule
`default_nettype wire

@@ hdl/mi3_prep.sv @@
// divider setup: magnitudes, signs, singular test, rounded dividend
// depends on mi3_pkg
`default_nettype none
module mi3_prep #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF,
  parameter int RW        = mi3_pkg::rem_width(FRAC_BITS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire mi3_pkg::adj_t adj_i [mi3_pkg::NUM_ENT],
  input  wire mi3_pkg::det_t det_i,
  output logic [RW-1:0]      rem_o [mi3_pkg::NUM_ENT],
  output logic [RW-1:0]      dv_o,
  output mi3_pkg::div_side_t side_o
);
  import mi3_pkg::*;

  logic [ADJ_W-1:0]   amag_q [NUM_ENT];
  logic [DET_W-1:0]   dmag_q;
  logic [NUM_ENT-1:0] neg_q;
  logic               zero_q;
  logic               v_q;
  logic [RW-1:0]      rem_q [NUM_ENT];
  logic [RW-1:0]      dv_q;
  div_side_t          side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      side_q <= '0;
    end else if (en_i) begin
      v_q          <= valid_i;
      side_q.valid <= v_q;
      side_q.zero  <= zero_q;
      side_q.neg   <= neg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        amag_q[k] <= adj_i[k][ADJ_W-1] ? -adj_i[k] : adj_i[k];
        neg_q[k]  <= adj_i[k][ADJ_W-1] ^ det_i[DET_W-1];
        rem_q[k]  <= (RW'(amag_q[k]) << (2 * FRAC_BITS + 1)) + RW'(dmag_q);
      end
      dmag_q <= det_i[DET_W-1] ? -det_i : det_i;
      zero_q <= (det_i == '0);
      dv_q   <= RW'(dmag_q) << 1;
    end
  end

  assign rem_o  = rem_q;
  assign dv_o   = dv_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

@@ hdl/mi3_div_step.sv @@
// one restoring division stage for all nine lanes, one quotient bit each
// depends on mi3_pkg
`default_nettype none
module mi3_div_step #(
  parameter int RW    = mi3_pkg::rem_width(mi3_pkg::FRAC_BITS_DEF),
  parameter int SHIFT = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic [RW-1:0]             rem_i [mi3_pkg::NUM_ENT],
  input  wire logic [mi3_pkg::QUO_W-1:0] q_i   [mi3_pkg::NUM_ENT],
  input  wire logic [RW-1:0]             dv_i,
  input  wire mi3_pkg::div_side_t        side_i,
  output logic [RW-1:0]                  rem_o [mi3_pkg::NUM_ENT],
  output logic [mi3_pkg::QUO_W-1:0]      q_o   [mi3_pkg::NUM_ENT],
  output logic [RW-1:0]                  dv_o,
  output mi3_pkg::div_side_t             side_o
);
  import mi3_pkg::*;

  logic [RW-1:0]    dsh;
  logic [RW-1:0]    rem_d [NUM_ENT];
  logic [QUO_W-1:0] q_d   [NUM_ENT];
  logic [RW-1:0]    rem_q [NUM_ENT];
  logic [QUO_W-1:0] q_q   [NUM_ENT];
  logic [RW-1:0]    dv_q;
  div_side_t        side_q;

  assign dsh = dv_i << SHIFT;

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      q_d[k] = q_i[k];
      if (rem_i[k] >= dsh) begin
        rem_d[k]     = rem_i[k] - dsh;
        q_d[k][SHIFT] = 1'b1;
      end else begin
        rem_d[k] = rem_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
      dv_q  <= dv_i;
    end
  end

  assign rem_o  = rem_q;
  assign q_o    = q_q;
  assign dv_o   = dv_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

@@ hdl/mi3_finish.sv @@
// sign restore, saturation and singular override into the output register
// depends on mi3_pkg
`default_nettype none
module mi3_finish (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic [mi3_pkg::QUO_W-1:0] q_i [mi3_pkg::NUM_ENT],
  input  wire mi3_pkg::div_side_t        side_i,
  output logic                           valid_o,
  output mi3_pkg::out_word_t             word_o
);
  import mi3_pkg::*;

  localparam logic [ELEM_WIDTH-1:0] HALF = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
  localparam logic [ELEM_WIDTH-1:0] MAXP = ~HALF;

  logic [ELEM_WIDTH-1:0] mag [NUM_ENT];
  logic [ELEM_WIDTH-1:0] val [NUM_ENT];
  logic [NUM_ENT-1:0]    sat;
  out_word_t             word_d;
  out_word_t             word_q;
  logic                  valid_q;

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      mag[k] = q_i[k][ELEM_WIDTH-1:0];
      sat[k] = 1'b0;
      if (side_i.zero) begin
        val[k] = '0;
      end else if (side_i.neg[k]) begin
        if (q_i[k][ELEM_WIDTH] || (mag[k] > HALF)) begin
          val[k] = HALF;
          sat[k] = 1'b1;
        end else begin
          val[k] = -mag[k];
        end
      end else begin
        if (q_i[k][ELEM_WIDTH] || (mag[k] > MAXP)) begin
          val[k] = MAXP;
          sat[k] = 1'b1;
        end else begin
          val[k] = mag[k];
        end
      end
    end
    word_d.out_r0c0  = val[0];
    word_d.out_r0c1  = val[1];
    word_d.out_r0c2  = val[2];
    word_d.out_r1c0  = val[3];
    word_d.out_r1c1  = val[4];
    word_d.out_r1c2  = val[5];
    word_d.out_r2c0  = val[6];
    word_d.out_r2c1  = val[7];
    word_d.out_r2c2  = val[8];
    word_d.singular  = side_i.zero;
    word_d.saturated = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

@@ hdl/matrix_inverse_3x3.sv @@
// 3x3 signed fixed-point matrix inverse via adjugate and determinant
// pipeline: 5 cofactor/determinant stages, the divider setup registers,
// a bit-per-stage restoring divider and the output register
// throughput: one word per cycle; a stalled output freezes the whole pipe
// reset: async active low, clears all valid bits, no clearing pass
`default_nettype none
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mi3_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mi3_pkg::out_word_t      out_word_o
);
  import mi3_pkg::*;

  localparam int RW     = rem_width(FRAC_BITS);
  localparam int NSTEPS = ELEM_WIDTH + 1;

  logic      en;
  logic      fr_valid;
  adj_t      fr_adj [NUM_ENT];
  det_t      fr_det;

  logic [RW-1:0]    rem_s  [NSTEPS+1][NUM_ENT];
  logic [QUO_W-1:0] q_s    [NSTEPS+1][NUM_ENT];
  logic [RW-1:0]    dv_s   [NSTEPS+1];
  div_side_t        side_s [NSTEPS+1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  mi3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (fr_valid),
    .adj_o   (fr_adj),
    .det_o   (fr_det)
  );

  mi3_prep #(
    .FRAC_BITS (FRAC_BITS),
    .RW        (RW)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .adj_i   (fr_adj),
    .det_i   (fr_det),
    .rem_o   (rem_s[0]),
    .dv_o    (dv_s[0]),
    .side_o  (side_s[0])
  );

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      q_s[0][k] = '0;
    end
  end

  for (genvar j = 0; j < NSTEPS; j++) begin : g_div
    mi3_div_step #(
      .RW    (RW),
      .SHIFT (ELEM_WIDTH - j)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rem_i  (rem_s[j]),
      .q_i    (q_s[j]),
      .dv_i   (dv_s[j]),
      .side_i (side_s[j]),
      .rem_o  (rem_s[j+1]),
      .q_o    (q_s[j+1]),
      .dv_o   (dv_s[j+1]),
      .side_o (side_s[j+1])
    );
  end

  mi3_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .q_i     (q_s[NSTEPS]),
    .side_i  (side_s[NSTEPS]),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

endmodule
`default_nettype wire

@@ hdl/mi3_checker.sv @@
// port-level checks for matrix_inverse_3x3, bound to the top level
// depends on mi3_pkg
`default_nettype none
module mi3_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire mi3_pkg::in_word_t  in_word_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire mi3_pkg::out_word_t out_word_o
);
  import mi3_pkg::*;

  // singular word is all zero with no saturation
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.singular) |->
      (out_word_o.out_r0c0 == '0) && (out_word_o.out_r0c1 == '0) &&
      (out_word_o.out_r0c2 == '0) && (out_word_o.out_r1c0 == '0) &&
      (out_word_o.out_r1c1 == '0) && (out_word_o.out_r1c2 == '0) &&
      (out_word_o.out_r2c0 == '0) && (out_word_o.out_r2c1 == '0) &&
      (out_word_o.out_r2c2 == '0) && !out_word_o.saturated)
    else $error("singular word not cleared");

  // input stalls only behind a held output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

  // stalled input word stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_word_i)))
    else $error("stalled input word changed");

  // no output word after a reset edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind matrix_inverse_3x3 mi3_checker u_chk (.*);
`default_nettype wire
